>>> rtl/slcb_pkg.sv
`timescale 1ns / 1ps
package slcb_pkg;

  localparam int SHARDS_DEF = 4;
  localparam int ENTRIES_DEF = 16;

  localparam int CMD_W = 3;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int COST_W = 16;
  localparam int STATUS_W = 3;
  localparam int EVICT_W = 5;
  localparam int TOT_E_W = 7;
  localparam int BYTES_W = 34;
  localparam int BUDGET_W = 32;
  localparam int SCNT_W = 3;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] CFG_BUDGET = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHARDS = 1'd1;

  localparam logic [BUDGET_W-1:0] BUDGET_RST = 32'd16777216;
  localparam logic [SCNT_W-1:0] SCNT_RST = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV, OP_SRCH, OP_RDHIT, OP_RDTAIL, OP_GETV, OP_UPD,
    OP_DET, OP_DROP, OP_ATT1, OP_ATT2, OP_INS, OP_FULL, OP_CLR, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_SRCH, S_RDHIT, S_GETV, S_UPD, S_DET, S_ATT1, S_ATT2,
    S_DROP, S_EVCHK, S_RDTAIL, S_INS, S_FULL, S_CLR, S_FIN
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   ready;
  } dp_cmd_t;

  typedef struct packed {
    logic             req_valid;
    logic             out_busy;
    logic             div_done;
    logic             srch_end;
    logic             hit;
    logic             need_evict;
    logic             ff_empty;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage

>>> rtl/slcb_if.sv
`timescale 1ns / 1ps
interface slcb_req_if;
  import slcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value_in;
  logic [COST_W-1:0] entry_cost;
  modport source(output valid, cmd, key, value_in, entry_cost, input ready);
  modport sink(input valid, cmd, key, value_in, entry_cost, output ready);
endinterface

interface slcb_rsp_if;
  import slcb_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    value_out;
  logic [EVICT_W-1:0]  evicted;
  logic [TOT_E_W-1:0]  total_entries;
  logic [BYTES_W-1:0]  total_bytes;
  modport source(output valid, status, value_out, evicted, total_entries, total_bytes,
                 input ready);
  modport sink(input valid, status, value_out, evicted, total_entries, total_bytes,
               output ready);
endinterface

interface slcb_cfg_if;
  import slcb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [BUDGET_W-1:0]   data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

>>> rtl/slcb_ram.sv
`timescale 1ns / 1ps
module slcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/slcb_ctrl.sv
`timescale 1ns / 1ps
module slcb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  slcb_pkg::dp_stat_t stat,
  output slcb_pkg::dp_cmd_t  ctl
);
  import slcb_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op = OP_NONE;
    ctl.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        ctl.op = OP_LOAD;
        if (stat.req_valid) state_next = S_DIV;
      end
      S_DIV: begin
        ctl.op = OP_DIV;
        if (stat.div_done) begin
          ctl.op = OP_NONE;
          if (stat.cmd == CMD_CLEAR) state_next = S_CLR;
          else if (stat.cmd == CMD_GET || stat.cmd == CMD_PUT ||
                   stat.cmd == CMD_DELETE || stat.cmd == CMD_CONTAINS)
            state_next = S_SRCH;
          else state_next = S_FIN;
        end
      end
      S_SRCH: begin
        if (!stat.srch_end) begin
          ctl.op = OP_SRCH;
        end else if (stat.hit) begin
          state_next = (stat.cmd == CMD_CONTAINS) ? S_FIN : S_RDHIT;
        end else begin
          state_next = (stat.cmd == CMD_PUT) ? S_EVCHK : S_FIN;
        end
      end
      S_RDHIT: begin
        ctl.op = OP_RDHIT;
        if (stat.cmd == CMD_GET) state_next = S_GETV;
        else if (stat.cmd == CMD_PUT) state_next = S_UPD;
        else state_next = S_DROP;
      end
      S_GETV: begin
        ctl.op = OP_GETV;
        state_next = S_DET;
      end
      S_UPD: begin
        ctl.op = OP_UPD;
        state_next = S_DET;
      end
      S_DET: begin
        ctl.op = OP_DET;
        state_next = S_ATT1;
      end
      S_ATT1: begin
        ctl.op = OP_ATT1;
        state_next = S_ATT2;
      end
      S_ATT2: begin
        ctl.op = OP_ATT2;
        state_next = S_FIN;
      end
      S_DROP: begin
        ctl.op = OP_DROP;
        state_next = (stat.cmd == CMD_DELETE) ? S_FIN : S_EVCHK;
      end
      S_EVCHK: begin
        if (stat.need_evict) state_next = S_RDTAIL;
        else if (stat.ff_empty) state_next = S_FULL;
        else state_next = S_INS;
      end
      S_RDTAIL: begin
        ctl.op = OP_RDTAIL;
        state_next = S_DROP;
      end
      S_INS: begin
        ctl.op = OP_INS;
        state_next = S_ATT1;
      end
      S_FULL: begin
        ctl.op = OP_FULL;
        state_next = S_FIN;
      end
      S_CLR: begin
        ctl.op = OP_CLR;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          ctl.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> rtl/slcb_dp.sv
`timescale 1ns / 1ps
module slcb_dp #(
  parameter int SHARDS = slcb_pkg::SHARDS_DEF,
  parameter int ENTRIES_PER_SHARD = slcb_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  slcb_req_if.sink                            req,
  slcb_rsp_if.source                          rsp,
  input  logic [slcb_pkg::BUDGET_W-1:0]       total_budget,
  input  logic [slcb_pkg::SCNT_W-1:0]         shard_count,
  input  slcb_pkg::dp_cmd_t                   ctl,
  output slcb_pkg::dp_stat_t                  stat
);
  import slcb_pkg::*;

  localparam int EPS = ENTRIES_PER_SHARD;
  localparam int SLOTS = SHARDS * EPS;
  localparam int LW = $clog2(EPS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam int SW = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int TEW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] EMPTY = LW'(EPS);
  localparam logic [5:0] DIV_STEPS = 6'd32;

  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [COST_W-1:0] cost_q;

  logic [SCNT_W-1:0]   act_c, c_q;
  logic [5:0]          div_cnt;
  logic [SCNT_W-1:0]   rem_k, rem_b;
  logic [KEY_W-1:0]    key_sh;
  logic [BUDGET_W-1:0] bud_sh;
  logic [SCNT_W:0]     tk, tb;

  logic [SW-1:0] sh;
  logic [AW-1:0] base;

  logic [SLOTS-1:0] valid;
  logic [LW-1:0]    head [SHARDS];
  logic [LW-1:0]    tail [SHARDS];
  logic [BYTES_W-1:0] sbytes [SHARDS];
  logic [TEW-1:0]   tot_e;
  logic [BYTES_W-1:0] tot_b;

  logic [LW-1:0] sidx, rd_idx, hit_idx, ff, tgt, ev;
  logic          rd_live, rd_v, hit_f, s_done;

  logic [STATUS_W-1:0] status_q;
  logic [VAL_W-1:0]    vout_q;

  logic                rsp_v;
  logic [STATUS_W-1:0] o_status;
  logic [VAL_W-1:0]    o_value;
  logic [EVICT_W-1:0]  o_ev;
  logic [TOT_E_W-1:0]  o_tot_e;
  logic [BYTES_W-1:0]  o_tot_b;

  logic key_re, slot_re;
  logic [AW-1:0] key_raddr, slot_raddr;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [COST_W-1:0] cost_rd;
  logic [LW-1:0] nrd, ord;

  logic key_we, val_we, cost_we, new_we, old_we;
  logic [AW-1:0] key_wa, val_wa, new_wa, old_wa;
  logic [VAL_W-1:0] val_wd;
  logic [LW-1:0] new_wd, old_wd;

  logic [LW-1:0] h;
  logic need_evict;

  always_comb begin
    if (shard_count == '0) act_c = SCNT_W'(1);
    else if (32'(shard_count) > SHARDS) act_c = SCNT_W'(SHARDS);
    else act_c = shard_count;
  end

  assign tk = {rem_k, key_sh[KEY_W-1]};
  assign tb = {rem_b, bud_sh[BUDGET_W-1]};
  assign sh = SW'(rem_k);
  assign base = AW'(sh) * AW'(EPS);
  assign h = head[sh];

  assign need_evict = ((35'(sbytes[sh]) + 35'(cost_q)) > 35'(bud_sh)) && (tail[sh] < EMPTY);

  assign stat.req_valid = req.valid;
  assign stat.out_busy = rsp_v && !rsp.ready;
  assign stat.div_done = (div_cnt == DIV_STEPS);
  assign stat.srch_end = s_done;
  assign stat.hit = hit_f;
  assign stat.need_evict = need_evict;
  assign stat.ff_empty = (ff == EMPTY);
  assign stat.cmd = cmd_q;

  assign req.ready = ctl.ready;
  assign rsp.valid = rsp_v;
  assign rsp.status = o_status;
  assign rsp.value_out = o_value;
  assign rsp.evicted = o_ev;
  assign rsp.total_entries = o_tot_e;
  assign rsp.total_bytes = o_tot_b;

  // read ports
  always_comb begin
    key_re = (ctl.op == OP_SRCH) && (sidx < EMPTY);
    key_raddr = base + AW'(sidx);
    slot_re = (ctl.op == OP_RDHIT) || (ctl.op == OP_RDTAIL);
    slot_raddr = base + AW'((ctl.op == OP_RDHIT) ? hit_idx : tail[sh]);
  end

  // write ports
  always_comb begin
    key_we = (ctl.op == OP_INS);
    key_wa = base + AW'(ff);
    val_we = (ctl.op == OP_INS) || (ctl.op == OP_UPD);
    val_wa = base + AW'((ctl.op == OP_INS) ? ff : tgt);
    val_wd = val_q;
    cost_we = val_we;
    new_we = 1'b0;
    new_wa = base + AW'(tgt);
    new_wd = EMPTY;
    old_we = 1'b0;
    old_wa = base + AW'(tgt);
    old_wd = h;
    unique case (ctl.op)
      OP_DET, OP_DROP: begin
        new_we = (ord < EMPTY);
        new_wa = base + AW'(ord);
        new_wd = nrd;
        old_we = (nrd < EMPTY);
        old_wa = base + AW'(nrd);
        old_wd = ord;
      end
      OP_ATT1: begin
        new_we = (h < EMPTY);
        new_wa = base + AW'(h);
        new_wd = tgt;
        old_we = 1'b1;
      end
      OP_ATT2: begin
        new_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  slcb_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_q),
    .re(key_re), .raddr(key_raddr), .rdata(key_rd));
  slcb_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
    .re(slot_re), .raddr(slot_raddr), .rdata(val_rd));
  slcb_ram #(.WIDTH(COST_W), .DEPTH(SLOTS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(val_wa), .wdata(cost_q),
    .re(slot_re), .raddr(slot_raddr), .rdata(cost_rd));
  slcb_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_newer (
    .clk(clk), .we(new_we), .waddr(new_wa), .wdata(new_wd),
    .re(slot_re), .raddr(slot_raddr), .rdata(nrd));
  slcb_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_older (
    .clk(clk), .we(old_we), .waddr(old_wa), .wdata(old_wd),
    .re(slot_re), .raddr(slot_raddr), .rdata(ord));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int s = 0; s < SHARDS; s++) begin
        head[s] <= EMPTY;
        tail[s] <= EMPTY;
        sbytes[s] <= '0;
      end
      tot_e <= '0;
      tot_b <= '0;
      rsp_v <= 1'b0;
      div_cnt <= DIV_STEPS;
      s_done <= 1'b0;
      rd_live <= 1'b0;
      hit_f <= 1'b0;
    end else begin
      if (ctl.op == OP_OUT) rsp_v <= 1'b1;
      else if (rsp.ready) rsp_v <= 1'b0;
      unique case (ctl.op)
        OP_LOAD: begin
          if (req.valid) begin
            cmd_q <= req.cmd;
            key_q <= req.key;
            val_q <= req.value_in;
            cost_q <= req.entry_cost;
            c_q <= act_c;
            key_sh <= req.key;
            bud_sh <= total_budget;
            rem_k <= '0;
            rem_b <= '0;
            div_cnt <= '0;
            sidx <= '0;
            rd_live <= 1'b0;
            hit_f <= 1'b0;
            s_done <= 1'b0;
            ff <= EMPTY;
            ev <= '0;
            status_q <= ST_MISS;
            vout_q <= '0;
          end
        end
        OP_DIV: begin
          if (div_cnt != DIV_STEPS) begin
            if (tk >= {1'b0, c_q}) rem_k <= SCNT_W'(tk - {1'b0, c_q});
            else rem_k <= tk[SCNT_W-1:0];
            if (tb >= {1'b0, c_q}) rem_b <= SCNT_W'(tb - {1'b0, c_q});
            else rem_b <= tb[SCNT_W-1:0];
            key_sh <= {key_sh[KEY_W-2:0], 1'b0};
            bud_sh <= {bud_sh[BUDGET_W-2:0], (tb >= {1'b0, c_q})};
            div_cnt <= div_cnt + 6'd1;
          end
        end
        OP_SRCH: begin
          if (sidx < EMPTY) begin
            rd_live <= 1'b1;
            rd_idx <= sidx;
            rd_v <= valid[base + AW'(sidx)];
            sidx <= sidx + LW'(1);
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live) begin
            if (rd_v && key_rd == key_q) begin
              hit_f <= 1'b1;
              hit_idx <= rd_idx;
              s_done <= 1'b1;
              status_q <= ST_HIT;
            end else begin
              if (!rd_v && ff == EMPTY) ff <= rd_idx;
              if (rd_idx == EMPTY - LW'(1)) s_done <= 1'b1;
            end
          end
        end
        OP_RDHIT: tgt <= hit_idx;
        OP_RDTAIL: tgt <= tail[sh];
        OP_GETV: vout_q <= val_rd;
        OP_UPD: begin
          vout_q <= val_rd;
          sbytes[sh] <= sbytes[sh] - BYTES_W'(cost_rd) + BYTES_W'(cost_q);
          tot_b <= tot_b - BYTES_W'(cost_rd) + BYTES_W'(cost_q);
          status_q <= ST_UPDATED;
        end
        OP_DET, OP_DROP: begin
          if (nrd >= EMPTY) head[sh] <= ord;
          if (ord >= EMPTY) tail[sh] <= nrd;
          if (ctl.op == OP_DROP) begin
            valid[base + AW'(tgt)] <= 1'b0;
            sbytes[sh] <= sbytes[sh] - BYTES_W'(cost_rd);
            tot_b <= tot_b - BYTES_W'(cost_rd);
            tot_e <= tot_e - TEW'(1);
            if (cmd_q == CMD_PUT) begin
              ev <= ev + LW'(1);
              if (tgt < ff) ff <= tgt;
            end
          end
        end
        OP_ATT1: begin
          if (h >= EMPTY) tail[sh] <= tgt;
        end
        OP_ATT2: head[sh] <= tgt;
        OP_INS: begin
          tgt <= ff;
          valid[base + AW'(ff)] <= 1'b1;
          sbytes[sh] <= sbytes[sh] + BYTES_W'(cost_q);
          tot_b <= tot_b + BYTES_W'(cost_q);
          tot_e <= tot_e + TEW'(1);
          status_q <= ST_INSERTED;
        end
        OP_FULL: status_q <= ST_DROPPED;
        OP_CLR: begin
          valid <= '0;
          for (int s = 0; s < SHARDS; s++) begin
            head[s] <= EMPTY;
            tail[s] <= EMPTY;
            sbytes[s] <= '0;
          end
          tot_e <= '0;
          tot_b <= '0;
          status_q <= ST_DONE;
        end
        OP_OUT: begin
          o_status <= status_q;
          o_value <= vout_q;
          o_ev <= EVICT_W'(ev);
          o_tot_e <= TOT_E_W'(tot_e);
          o_tot_b <= tot_b;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

>>> rtl/sharded_lru_cache_byte_budget.sv
`timescale 1ns / 1ps
// Sharded LRU cache with a byte budget per shard.
// req: one request per command (get, put, delete, contains, clear) with key,
//   value and byte cost; taken when valid and ready are high together.
// rsp: one response per request with status, value, eviction count and the
//   entry and byte totals over all shards.
// cfg: register writes (0 total budget, 1 shard count), always ready; write
//   only while no request is in flight.
// A request is taken only when the block is idle. From acceptance to response
// it passes the shard/budget divider, the tag scan through the key memory
// (one slot a cycle), the relink steps for a hit that relinks, a tail read
// and drop per evicted entry, an insert, and the response register.
// The next request can be taken in the cycle after the response is loaded,
// while it still waits; a held response stalls the following one.
// Reset empties every shard, clears the totals and loads the register
// defaults; the slot memories are not cleared.
module sharded_lru_cache_byte_budget #(
  parameter int SHARDS = slcb_pkg::SHARDS_DEF,
  parameter int ENTRIES_PER_SHARD = slcb_pkg::ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  slcb_req_if.sink   req,
  slcb_rsp_if.source rsp,
  slcb_cfg_if.sink   cfg
);
  import slcb_pkg::*;

  logic [BUDGET_W-1:0] total_budget;
  logic [SCNT_W-1:0]   shard_count;
  dp_cmd_t  ctl;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_budget <= BUDGET_RST;
      shard_count <= SCNT_RST;
    end else if (cfg.valid) begin
      if (cfg.addr == CFG_BUDGET) total_budget <= cfg.data;
      else if (cfg.addr == CFG_SHARDS) shard_count <= cfg.data[SCNT_W-1:0];
    end
  end

  slcb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .ctl(ctl));

  slcb_dp #(.SHARDS(SHARDS), .ENTRIES_PER_SHARD(ENTRIES_PER_SHARD)) u_dp (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .total_budget(total_budget), .shard_count(shard_count),
    .ctl(ctl), .stat(stat));
endmodule
